[hw/rtl/rmq_pkg.sv]
package rmq_pkg;

	localparam int unsigned ELEM_W = 16;
	localparam int unsigned SUM_W = 17;
	localparam int unsigned ROOT_W = 16;
	localparam int unsigned RAD_W = 32;
	localparam int unsigned REM_W = 19;
	localparam int unsigned NUM_W = 30;
	localparam int unsigned QUO_W = 16;

	localparam logic [1:0] SLOT_X = 2'd0;
	localparam logic [1:0] SLOT_Y = 2'd1;
	localparam logic [1:0] SLOT_Z = 2'd2;
	localparam logic [1:0] SLOT_W = 2'd3;

	typedef struct packed {
		logic signed [ELEM_W-1:0] m11;
		logic signed [ELEM_W-1:0] m12;
		logic signed [ELEM_W-1:0] m13;
		logic signed [ELEM_W-1:0] m21;
		logic signed [ELEM_W-1:0] m22;
		logic signed [ELEM_W-1:0] m23;
		logic signed [ELEM_W-1:0] m31;
		logic signed [ELEM_W-1:0] m32;
		logic signed [ELEM_W-1:0] m33;
	} matrix_t;

	typedef struct packed {
		logic signed [ELEM_W-1:0] quat_x;
		logic signed [ELEM_W-1:0] quat_y;
		logic signed [ELEM_W-1:0] quat_z;
		logic signed [ELEM_W-1:0] quat_w;
		logic                     degenerate;
	} quat_t;

	// per-item side data that rides along the square-root stages
	typedef struct packed {
		logic signed [SUM_W-1:0] d_x;
		logic signed [SUM_W-1:0] d_y;
		logic signed [SUM_W-1:0] d_z;
		logic signed [SUM_W-1:0] d_w;
		logic [1:0]              big_slot;
		logic                    degenerate;
	} item_ctrl_t;

	// side data that rides along the divider stages
	typedef struct packed {
		logic [1:0]              big_slot;
		logic [ELEM_W-1:0]       big_val;
		logic                    degenerate;
	} out_ctrl_t;

endpackage

[hw/rtl/rmq_pre.sv]
module rmq_pre (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  rmq_pkg::matrix_t     matrix,
	output logic                 valid_s1,
	output logic [rmq_pkg::RAD_W-1:0] rad_s1,
	output rmq_pkg::item_ctrl_t  ctrl_s1
);

	logic signed [17:0] trace;
	logic signed [18:0] arg;
	logic signed [18:0] e11, e22, e33;
	logic signed [rmq_pkg::SUM_W-1:0] m12p21, m13p31, m23p32;
	logic signed [rmq_pkg::SUM_W-1:0] m23m32, m31m13, m12m21;
	logic [1:0] branch;
	logic deg;
	rmq_pkg::item_ctrl_t ctrl;

	assign e11 = 19'(matrix.m11);
	assign e22 = 19'(matrix.m22);
	assign e33 = 19'(matrix.m33);
	assign trace = 18'(e11 + e22 + e33);

	assign m12p21 = 17'(matrix.m12) + 17'(matrix.m21);
	assign m13p31 = 17'(matrix.m13) + 17'(matrix.m31);
	assign m23p32 = 17'(matrix.m23) + 17'(matrix.m32);
	assign m23m32 = 17'(matrix.m23) - 17'(matrix.m32);
	assign m31m13 = 17'(matrix.m31) - 17'(matrix.m13);
	assign m12m21 = 17'(matrix.m12) - 17'(matrix.m21);

	always_comb begin
		if (trace > 18'sd0) begin
			branch = rmq_pkg::SLOT_W;
			arg = 19'(trace) + 19'sd16384;
		end else if (matrix.m11 >= matrix.m22 && matrix.m11 >= matrix.m33) begin
			branch = rmq_pkg::SLOT_X;
			arg = 19'sd16384 + e11 - e22 - e33;
		end else if (matrix.m22 > matrix.m33) begin
			branch = rmq_pkg::SLOT_Y;
			arg = 19'sd16384 + e22 - e11 - e33;
		end else begin
			branch = rmq_pkg::SLOT_Z;
			arg = 19'sd16384 + e33 - e11 - e22;
		end
	end

	assign deg = (arg <= 19'sd0);

	always_comb begin
		ctrl.big_slot = branch;
		ctrl.degenerate = deg;
		ctrl.d_x = m23m32;
		ctrl.d_y = m31m13;
		ctrl.d_z = m12m21;
		ctrl.d_w = m23m32;
		case (branch)
			rmq_pkg::SLOT_X: begin
				ctrl.d_y = m12p21;
				ctrl.d_z = m13p31;
				ctrl.d_w = m23m32;
			end
			rmq_pkg::SLOT_Y: begin
				ctrl.d_x = m12p21;
				ctrl.d_z = m23p32;
				ctrl.d_w = m31m13;
			end
			rmq_pkg::SLOT_Z: begin
				ctrl.d_x = m13p31;
				ctrl.d_y = m23p32;
				ctrl.d_w = m12m21;
			end
			default: begin
				ctrl.d_x = m23m32;
				ctrl.d_y = m31m13;
				ctrl.d_z = m12m21;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		ctrl_s1 <= ctrl;
		rad_s1 <= deg ? '0 : {1'b0, arg[16:0], 14'd0};
	end

endmodule

[hw/rtl/rmq_sqrt.sv]
module rmq_sqrt (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	input  logic [rmq_pkg::RAD_W-1:0] rad,
	input  rmq_pkg::item_ctrl_t       in_ctrl,
	output logic                      out_valid,
	output logic [rmq_pkg::ROOT_W-1:0] root,
	output rmq_pkg::item_ctrl_t       out_ctrl
);

	localparam int unsigned NSTG = rmq_pkg::ROOT_W;

	logic                       valid_s [0:NSTG];
	logic [rmq_pkg::RAD_W-1:0]  rad_s   [0:NSTG];
	logic [rmq_pkg::REM_W-1:0]  rem_s   [0:NSTG];
	logic [rmq_pkg::ROOT_W-1:0] root_s  [0:NSTG];
	rmq_pkg::item_ctrl_t        ctrl_s  [0:NSTG];

	assign valid_s[0] = in_valid;
	assign rad_s[0] = rad;
	assign rem_s[0] = '0;
	assign root_s[0] = '0;
	assign ctrl_s[0] = in_ctrl;

	for (genvar k = 0; k < NSTG; k++) begin : g_stage
		logic [rmq_pkg::REM_W-1:0] rem_sh;
		logic [rmq_pkg::REM_W-1:0] trial;
		logic take;

		// one result bit per stage: bring down the next radicand bit pair
		assign rem_sh = {rem_s[k][rmq_pkg::REM_W-3:0],
			rad_s[k][2*(NSTG-1-k)+1 -: 2]};
		assign trial = {1'b0, root_s[k], 2'b01};
		assign take = (rem_sh >= trial);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k+1] <= 1'b0;
			end else begin
				valid_s[k+1] <= valid_s[k];
			end
		end

		always_ff @(posedge clk) begin
			rad_s[k+1] <= rad_s[k];
			ctrl_s[k+1] <= ctrl_s[k];
			rem_s[k+1] <= take ? rem_sh - trial : rem_sh;
			root_s[k+1] <= {root_s[k][rmq_pkg::ROOT_W-2:0], take};
		end
	end

	assign out_valid = valid_s[NSTG];
	assign root = root_s[NSTG];
	assign out_ctrl = ctrl_s[NSTG];

endmodule

[hw/rtl/rmq_div.sv]
module rmq_div (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	input  logic signed [rmq_pkg::SUM_W-1:0]  dval,
	input  logic [rmq_pkg::ROOT_W-1:0]        root,
	output logic                              out_valid,
	output logic signed [rmq_pkg::ELEM_W-1:0] quot
);

	localparam int unsigned NSTG = rmq_pkg::QUO_W;
	localparam int unsigned RW = rmq_pkg::ROOT_W + 1;

	logic [rmq_pkg::SUM_W-1:0] mag;
	logic [rmq_pkg::NUM_W-1:0] num;
	logic [31:0] lim;

	assign mag = dval[rmq_pkg::SUM_W-1] ? 17'(-dval) : 17'(dval);
	assign num = {mag, 13'd0} + 30'(root[rmq_pkg::ROOT_W-1:1]);
	assign lim = {root, 16'd0};

	logic                        valid_s [0:NSTG];
	logic [rmq_pkg::QUO_W-1:0]   low_s   [0:NSTG];
	logic [RW-1:0]               rem_s   [0:NSTG];
	logic [rmq_pkg::QUO_W-1:0]   q_s     [0:NSTG];
	logic [rmq_pkg::ROOT_W-1:0]  den_s   [0:NSTG];
	logic                        neg_s   [0:NSTG];
	logic                        ovf_s   [0:NSTG];

	// setup stage: magnitude, rounding bias and overflow check
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s[0] <= 1'b0;
		end else begin
			valid_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		low_s[0] <= num[15:0];
		rem_s[0] <= RW'(num[rmq_pkg::NUM_W-1:16]);
		q_s[0] <= '0;
		den_s[0] <= root;
		neg_s[0] <= dval[rmq_pkg::SUM_W-1];
		ovf_s[0] <= (32'(num) >= lim);
	end

	for (genvar k = 0; k < NSTG; k++) begin : g_stage
		logic [RW-1:0] rem_sh;
		logic take;

		assign rem_sh = {rem_s[k][RW-2:0], low_s[k][NSTG-1-k]};
		assign take = (rem_sh >= RW'(den_s[k]));

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k+1] <= 1'b0;
			end else begin
				valid_s[k+1] <= valid_s[k];
			end
		end

		always_ff @(posedge clk) begin
			low_s[k+1] <= low_s[k];
			den_s[k+1] <= den_s[k];
			neg_s[k+1] <= neg_s[k];
			ovf_s[k+1] <= ovf_s[k];
			rem_s[k+1] <= take ? rem_sh - RW'(den_s[k]) : rem_sh;
			q_s[k+1] <= {q_s[k][rmq_pkg::QUO_W-2:0], take};
		end
	end

	// saturate to the signed output range
	always_comb begin
		if (neg_s[NSTG]) begin
			if (ovf_s[NSTG] || q_s[NSTG] > 16'd32768) begin
				quot = 16'sh8000;
			end else begin
				quot = 16'(-q_s[NSTG]);
			end
		end else begin
			if (ovf_s[NSTG] || q_s[NSTG] > 16'd32767) begin
				quot = 16'sh7fff;
			end else begin
				quot = 16'(q_s[NSTG]);
			end
		end
	end

	assign out_valid = valid_s[NSTG];

endmodule

[hw/rtl/rotation_matrix_to_quaternion_top.sv]
// Throughput: one matrix per cycle; busy stays low, items enter back to back.
// The pipeline is a 16-stage square root, a 17-stage divider and in/out registers.
// Reset: arst_n clears all valid bits at once; payload registers are not reset.
// The receiver cannot stall: each result shows for one cycle with done high.
module rotation_matrix_to_quaternion_top (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  rmq_pkg::matrix_t matrix,
	output logic             done,
	output rmq_pkg::quat_t   result
);

	localparam int unsigned DIV_LAT = rmq_pkg::QUO_W + 1;

	logic                      valid_s1;
	logic [rmq_pkg::RAD_W-1:0] rad_s1;
	rmq_pkg::item_ctrl_t       ctrl_s1;

	logic                       sq_valid;
	logic [rmq_pkg::ROOT_W-1:0] sq_root;
	rmq_pkg::item_ctrl_t        sq_ctrl;

	logic dv_valid [0:3];
	logic signed [rmq_pkg::ELEM_W-1:0] dv_q [0:3];
	logic signed [rmq_pkg::SUM_W-1:0]  dv_d [0:3];

	rmq_pkg::out_ctrl_t oc_in;
	rmq_pkg::out_ctrl_t oc_s [0:DIV_LAT];
	rmq_pkg::out_ctrl_t oc_out;
	logic [rmq_pkg::ROOT_W:0] root_inc;

	logic done_q;
	rmq_pkg::quat_t result_q;
	rmq_pkg::quat_t res_next;

	assign busy = 1'b0;

	rmq_pre u_pre (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (start),
		.matrix   (matrix),
		.valid_s1 (valid_s1),
		.rad_s1   (rad_s1),
		.ctrl_s1  (ctrl_s1)
	);

	rmq_sqrt u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid_s1),
		.rad       (rad_s1),
		.in_ctrl   (ctrl_s1),
		.out_valid (sq_valid),
		.root      (sq_root),
		.out_ctrl  (sq_ctrl)
	);

	assign dv_d[0] = sq_ctrl.d_x;
	assign dv_d[1] = sq_ctrl.d_y;
	assign dv_d[2] = sq_ctrl.d_z;
	assign dv_d[3] = sq_ctrl.d_w;

	for (genvar i = 0; i < 4; i++) begin : g_lane
		rmq_div u_div (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (sq_valid),
			.dval      (dv_d[i]),
			.root      (sq_root),
			.out_valid (dv_valid[i]),
			.quot      (dv_q[i])
		);
	end

	// main component: root/2 rounded half up, always within range
	assign root_inc = 17'(sq_root) + 17'd1;
	assign oc_in.big_slot = sq_ctrl.big_slot;
	assign oc_in.big_val = root_inc[rmq_pkg::ROOT_W:1];
	assign oc_in.degenerate = sq_ctrl.degenerate;

	assign oc_s[0] = oc_in;
	for (genvar k = 0; k < DIV_LAT; k++) begin : g_delay
		always_ff @(posedge clk) begin
			oc_s[k+1] <= oc_s[k];
		end
	end
	assign oc_out = oc_s[DIV_LAT];

	always_comb begin
		res_next.quat_x = dv_q[0];
		res_next.quat_y = dv_q[1];
		res_next.quat_z = dv_q[2];
		res_next.quat_w = dv_q[3];
		res_next.degenerate = 1'b0;
		case (oc_out.big_slot)
			rmq_pkg::SLOT_X: res_next.quat_x = oc_out.big_val;
			rmq_pkg::SLOT_Y: res_next.quat_y = oc_out.big_val;
			rmq_pkg::SLOT_Z: res_next.quat_z = oc_out.big_val;
			default:         res_next.quat_w = oc_out.big_val;
		endcase
		if (oc_out.degenerate) begin
			res_next = '0;
			res_next.degenerate = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= dv_valid[0] & dv_valid[3];
		end
	end

	always_ff @(posedge clk) begin
		result_q <= res_next;
	end

	assign done = done_q;
	assign result = result_q;

endmodule
